/* sv/bdb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_pkg
// Shared types, codes and helpers for the B-spline evaluator.
// ----------------------------------------------------------------------------
package bdb_pkg;

    localparam int CoordW       = 32;
    localparam int DiffW        = CoordW + 1;
    localparam int AlphaW       = 33;
    localparam int ProdW        = AlphaW + DiffW;
    localparam int SatW         = 72;
    localparam int MaxPointsDef = 64;
    localparam int MaxDegreeDef = 3;

    localparam logic [1:0] CMD_WR_POINT = 2'd0;
    localparam logic [1:0] CMD_WR_KNOT  = 2'd1;
    localparam logic [1:0] CMD_FILL     = 2'd2;
    localparam logic [1:0] CMD_EVAL     = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_FEW_PTS  = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    localparam logic [1:0] CFG_DEGREE   = 2'd0;
    localparam logic [1:0] CFG_PCOUNT   = 2'd1;
    localparam logic [1:0] CFG_INTERVAL = 2'd2;

    localparam logic [4:0] OP_NONE     = 5'd0;
    localparam logic [4:0] OP_LATCH    = 5'd1;
    localparam logic [4:0] OP_WRITE    = 5'd2;
    localparam logic [4:0] OP_CFGFAIL  = 5'd3;
    localparam logic [4:0] OP_FILLINIT = 5'd4;
    localparam logic [4:0] OP_FILL     = 5'd5;
    localparam logic [4:0] OP_CLAMP_RD = 5'd6;
    localparam logic [4:0] OP_CLAMP    = 5'd7;
    localparam logic [4:0] OP_SRCH_RD  = 5'd8;
    localparam logic [4:0] OP_SRCH_INC = 5'd9;
    localparam logic [4:0] OP_LOAD_RD  = 5'd10;
    localparam logic [4:0] OP_LOAD_PSH = 5'd11;
    localparam logic [4:0] OP_STEP_RD  = 5'd12;
    localparam logic [4:0] OP_ROTATE   = 5'd13;
    localparam logic [4:0] OP_DIV      = 5'd14;
    localparam logic [4:0] OP_ALPHA    = 5'd15;
    localparam logic [4:0] OP_MUL      = 5'd16;
    localparam logic [4:0] OP_ADD      = 5'd17;
    localparam logic [4:0] OP_BLD_PSH  = 5'd18;
    localparam logic [4:0] OP_FINISH   = 5'd19;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [6:0]               entry_index;
        logic signed [CoordW-1:0] coord_x;
        logic signed [CoordW-1:0] coord_y;
        logic signed [CoordW-1:0] coord_z;
        logic signed [CoordW-1:0] knot_value;
        logic signed [CoordW-1:0] param_u;
    } t_in;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic signed [CoordW-1:0] pos_z;
        logic [6:0]               span_found;
        logic [1:0]               status;
    } t_out;

    typedef logic [2:0][CoordW-1:0] t_vec;

    typedef struct packed {
        logic [4:0] op;
    } t_ctl;

    typedef struct packed {
        logic is_write;
        logic is_fill;
        logic cfg_bad;
        logic srch_more;
        logic srch_less;
        logic lane_last;
        logic round_last;
        logic lane_active;
        logic den_zero;
        logic div_done;
        logic fill_last;
        logic coord_last;
    } t_sts;

    function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [SatW-1:0] v);
        logic signed [SatW-1:0] hi;
        logic signed [SatW-1:0] lo;
        hi = SatW'({1'b0, {(CoordW-1){1'b1}}});
        lo = -hi - SatW'(1);
        if (v > hi) begin
            return hi[CoordW-1:0];
        end else if (v < lo) begin
            return lo[CoordW-1:0];
        end
        return v[CoordW-1:0];
    endfunction

endpackage

/* sv/bdb_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_div
// Radix-2 restoring divider for the blend weight, Q2.30, clamped to +-2.
// ----------------------------------------------------------------------------
module bdb_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [bdb_pkg::DiffW-1:0]   i_num,
    input  logic signed [bdb_pkg::DiffW-1:0]   i_den,
    output logic                               o_done,
    output logic signed [bdb_pkg::AlphaW-1:0]  o_alpha
);
    import bdb_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_sh;
    logic [31:0] r_quo;
    logic [31:0] r_d;
    logic        r_neg;
    logic        r_ovf;

    logic [31:0]       an;
    logic [31:0]       ad;
    logic [32:0]       trial;
    logic [AlphaW-1:0] mag;

    always_comb begin
        an    = i_num[DiffW-1] ? 32'(-i_num) : 32'(i_num);
        ad    = i_den[DiffW-1] ? 32'(-i_den) : 32'(i_den);
        trial = {r_rem, r_sh[31]};
        if (r_ovf || r_quo > 32'h8000_0000) begin
            mag = AlphaW'(33'h0_8000_0000);
        end else begin
            mag = AlphaW'(r_quo);
        end
        o_alpha = r_neg ? -$signed(mag) : $signed(mag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, an[31:2]};
            r_sh  <= {an[1:0], 30'd0};
            r_d   <= ad;
            r_quo <= '0;
            r_neg <= i_num[DiffW-1] ^ i_den[DiffW-1];
            r_ovf <= {2'b00, an[31:2]} >= ad;
        end else if (r_busy) begin
            r_sh <= {r_sh[30:0], 1'b0};
            if (trial >= {1'b0, r_d}) begin
                r_rem <= 32'(trial - {1'b0, r_d});
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= trial[31:0];
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;

endmodule

/* sv/bdb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_datapath
// Point and knot stores, configuration, span search, blend lanes and result.
// ----------------------------------------------------------------------------
module bdb_datapath #(
    parameter int MAX_POINTS = bdb_pkg::MaxPointsDef,
    parameter int MAX_DEGREE = bdb_pkg::MaxDegreeDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bdb_pkg::t_in     i_item,
    input  bdb_pkg::t_ctl    i_ctl,
    output bdb_pkg::t_sts    o_sts,
    output bdb_pkg::t_out    o_result,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data
);
    import bdb_pkg::*;

    localparam int KnotDepth = MAX_POINTS + MAX_DEGREE + 1;
    localparam int PAW       = $clog2(MAX_POINTS);
    localparam int KAW       = $clog2(KnotDepth);
    localparam int Lanes     = MAX_DEGREE + 1;
    localparam int LW        = (Lanes > 2) ? $clog2(Lanes) : 1;
    localparam int AccW      = CoordW + KAW + 2;
    localparam logic signed [ProdW-1:0] RndHalf = ProdW'(64'd536870912);

    logic [3*CoordW-1:0]      r_pts_mem [MAX_POINTS];
    logic [CoordW-1:0]        r_knot_mem [KnotDepth];

    t_in                      r_item;
    logic [1:0]               r_degree;
    logic [6:0]               r_pcount;
    logic [30:0]              r_interval;
    logic [1:0]               r_status;
    t_vec                     r_pos;
    logic [6:0]               r_span;
    logic [KAW-1:0]           r_k;
    logic signed [CoordW-1:0] r_u;
    logic [LW-1:0]            r_i;
    logic [1:0]               r_r;
    logic [1:0]               r_c;
    t_vec                     r_q [Lanes];
    t_vec                     r_prev;
    t_vec                     r_res;
    logic signed [AlphaW-1:0] r_alpha;
    logic signed [ProdW-1:0]  r_prod;
    logic signed [AccW-1:0]   r_acc;
    logic [KAW-1:0]           r_fi;
    logic signed [CoordW-1:0] r_ka;
    logic signed [CoordW-1:0] r_kb;
    t_vec                     r_pt;

    logic [4:0]               op;
    logic [1:0]               cfg_code;
    logic                     pt_in_range;
    logic                     kn_in_range;
    logic [KAW-1:0]           ka_addr;
    logic [KAW-1:0]           kb_addr;
    logic [PAW-1:0]           pt_addr;
    logic                     pt_we;
    logic                     kn_we;
    logic [KAW-1:0]           kn_wa;
    logic [CoordW-1:0]        kn_wd;
    logic                     lane_le_p;
    logic                     lane_last;
    logic signed [CoordW-1:0] hd;
    logic signed [CoordW-1:0] pv;
    logic signed [DiffW-1:0]  diff;
    logic signed [ProdW-1:0]  rnd;
    logic signed [ProdW-1:0]  shd;
    logic signed [SatW-1:0]   sum;
    logic signed [CoordW-1:0] blend_val;
    logic signed [CoordW-1:0] ub_lo;
    logic signed [CoordW-1:0] ub;
    logic signed [DiffW-1:0]  div_num;
    logic signed [DiffW-1:0]  div_den;
    logic                     div_start;
    logic                     div_done;
    logic signed [AlphaW-1:0] div_alpha;

    assign op = i_ctl.op;

    always_comb begin
        if (r_degree == 2'd0 || 32'(r_degree) > MAX_DEGREE || 32'(r_pcount) > MAX_POINTS) begin
            cfg_code = ST_RANGE;
        end else if (32'(r_pcount) < 32'(r_degree) + 32'd1) begin
            cfg_code = ST_FEW_PTS;
        end else begin
            cfg_code = ST_OK;
        end
        pt_in_range = 32'(r_item.entry_index) < MAX_POINTS;
        kn_in_range = 32'(r_item.entry_index) < KnotDepth;
        lane_le_p   = 32'(r_i) <= 32'(r_degree);
        lane_last   = 32'(r_i) == Lanes - 1;
    end

    always_comb begin
        ka_addr = '0;
        kb_addr = '0;
        unique case (op)
            OP_CLAMP_RD: begin
                ka_addr = KAW'(r_degree);
                kb_addr = KAW'(r_pcount);
            end
            OP_SRCH_RD: begin
                ka_addr = KAW'(32'(r_k) + 32'd1);
            end
            OP_STEP_RD: begin
                ka_addr = KAW'(32'(r_i) + 32'(r_k) - 32'(r_degree));
                kb_addr = KAW'(32'(r_i) + 32'd1 + 32'(r_k) - 32'(r_r));
            end
            default: begin
            end
        endcase
        pt_addr = lane_le_p ? PAW'(32'(r_k) - 32'(r_degree) + 32'(r_i)) : '0;
    end

    always_comb begin
        pt_we = (op == OP_WRITE) && (r_item.cmd == CMD_WR_POINT) && pt_in_range;
        kn_we = ((op == OP_WRITE) && (r_item.cmd == CMD_WR_KNOT) && kn_in_range)
              || (op == OP_FILL);
        if (op == OP_FILL) begin
            kn_wa = r_fi;
            kn_wd = sat_coord(SatW'(r_acc));
        end else begin
            kn_wa = KAW'(r_item.entry_index);
            kn_wd = r_item.knot_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            r_pts_mem[PAW'(r_item.entry_index)] <= {r_item.coord_z, r_item.coord_y,
                                                    r_item.coord_x};
        end
        r_pt <= r_pts_mem[pt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (kn_we) begin
            r_knot_mem[kn_wa] <= kn_wd;
        end
        r_ka <= r_knot_mem[ka_addr];
        r_kb <= r_knot_mem[kb_addr];
    end

    always_comb begin
        hd        = r_q[0][r_c];
        pv        = r_prev[r_c];
        diff      = $signed({hd[CoordW-1], hd}) - $signed({pv[CoordW-1], pv});
        rnd       = r_prod + RndHalf;
        shd       = rnd >>> 30;
        sum       = SatW'(shd) + SatW'(pv);
        blend_val = sat_coord(sum);
        ub_lo     = (r_item.param_u < r_ka) ? r_ka : r_item.param_u;
        ub        = (ub_lo > r_kb) ? r_kb : ub_lo;
        div_num   = $signed({r_u[CoordW-1], r_u}) - $signed({r_ka[CoordW-1], r_ka});
        div_den   = $signed({r_kb[CoordW-1], r_kb}) - $signed({r_ka[CoordW-1], r_ka});
        div_start = (op == OP_DIV) && (r_kb != r_ka);
    end

    bdb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_alpha (div_alpha)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree   <= 2'd3;
            r_pcount   <= 7'd4;
            r_interval <= 31'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEGREE:   r_degree   <= i_cfg_data[1:0];
                CFG_PCOUNT:   r_pcount   <= i_cfg_data[6:0];
                CFG_INTERVAL: r_interval <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (op)
            OP_LATCH: begin
                r_item   <= i_item;
                r_status <= ST_OK;
                r_pos    <= '0;
                r_span   <= '0;
            end
            OP_WRITE: begin
                if ((r_item.cmd == CMD_WR_POINT && !pt_in_range)
                    || (r_item.cmd == CMD_WR_KNOT && !kn_in_range)) begin
                    r_status <= ST_RANGE;
                end
            end
            OP_CFGFAIL: r_status <= cfg_code;
            OP_FILLINIT: begin
                r_acc <= -($signed(AccW'(r_interval)) * $signed(AccW'(r_degree)));
                r_fi  <= '0;
            end
            OP_FILL: begin
                r_acc <= r_acc + $signed(AccW'(r_interval));
                r_fi  <= r_fi + KAW'(1);
            end
            OP_CLAMP: begin
                r_u <= ub;
                r_k <= KAW'(r_degree);
                r_i <= '0;
            end
            OP_SRCH_INC: r_k <= r_k + KAW'(1);
            OP_LOAD_PSH: begin
                for (int j = 0; j < Lanes - 1; j++) begin
                    r_q[j] <= r_q[j+1];
                end
                r_q[Lanes-1] <= lane_le_p ? r_pt : '0;
                r_i <= lane_last ? '0 : r_i + LW'(1);
                r_r <= 2'd1;
            end
            OP_ROTATE, OP_BLD_PSH: begin
                for (int j = 0; j < Lanes - 1; j++) begin
                    r_q[j] <= r_q[j+1];
                end
                r_q[Lanes-1] <= (op == OP_BLD_PSH) ? r_res : r_q[0];
                r_prev <= r_q[0];
                if (lane_last) begin
                    r_i <= '0;
                    r_r <= r_r + 2'd1;
                end else begin
                    r_i <= r_i + LW'(1);
                end
            end
            OP_DIV: begin
                r_c <= '0;
                if (r_kb == r_ka) begin
                    r_status <= ST_ZERO_DEN;
                    r_alpha  <= '0;
                end
            end
            OP_ALPHA: r_alpha <= div_alpha;
            OP_MUL:   r_prod  <= r_alpha * diff;
            OP_ADD: begin
                r_res[r_c] <= blend_val;
                r_c        <= (r_c == 2'd2) ? 2'd0 : r_c + 2'd1;
            end
            OP_FINISH: begin
                r_pos  <= r_q[LW'(r_degree)];
                r_span <= 7'(r_k);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_sts.is_write    = (r_item.cmd == CMD_WR_POINT) || (r_item.cmd == CMD_WR_KNOT);
        o_sts.is_fill     = r_item.cmd == CMD_FILL;
        o_sts.cfg_bad     = cfg_code != ST_OK;
        o_sts.srch_more   = 32'(r_k) + 32'd1 < 32'(r_pcount);
        o_sts.srch_less   = r_ka < r_u;
        o_sts.lane_last   = lane_last;
        o_sts.round_last  = r_r == r_degree;
        o_sts.lane_active = (32'(r_i) >= 32'(r_r)) && lane_le_p;
        o_sts.den_zero    = r_kb == r_ka;
        o_sts.div_done    = div_done;
        o_sts.fill_last   = 32'(r_fi) == 32'(r_pcount) + 32'(r_degree);
        o_sts.coord_last  = r_c == 2'd2;

        o_result.pos_x      = r_pos[0];
        o_result.pos_y      = r_pos[1];
        o_result.pos_z      = r_pos[2];
        o_result.span_found = r_span;
        o_result.status     = r_status;
    end

endmodule

/* sv/bdb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_ctrl
// Command sequencer: dispatch, knot fill, span search, load and blend rounds.
// ----------------------------------------------------------------------------
module bdb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  bdb_pkg::t_sts i_sts,
    output bdb_pkg::t_ctl o_ctl,
    output logic          o_busy,
    output logic          o_done
);
    import bdb_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_FILL  = 5'd2;
    localparam logic [4:0] S_CLAMP = 5'd3;
    localparam logic [4:0] S_SRD   = 5'd4;
    localparam logic [4:0] S_SCMP  = 5'd5;
    localparam logic [4:0] S_LRD   = 5'd6;
    localparam logic [4:0] S_LPUSH = 5'd7;
    localparam logic [4:0] S_STEP  = 5'd8;
    localparam logic [4:0] S_KNOT  = 5'd9;
    localparam logic [4:0] S_DIVW  = 5'd10;
    localparam logic [4:0] S_MUL   = 5'd11;
    localparam logic [4:0] S_ADD   = 5'd12;
    localparam logic [4:0] S_PUSH  = 5'd13;
    localparam logic [4:0] S_FIN   = 5'd14;
    localparam logic [4:0] S_RES   = 5'd15;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic [4:0] op;
    logic       all_done;

    always_comb begin
        n_state  = r_state;
        op       = OP_NONE;
        all_done = i_sts.lane_last && i_sts.round_last;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    op      = OP_LATCH;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_write) begin
                    op      = OP_WRITE;
                    n_state = S_RES;
                end else if (i_sts.cfg_bad) begin
                    op      = OP_CFGFAIL;
                    n_state = S_RES;
                end else if (i_sts.is_fill) begin
                    op      = OP_FILLINIT;
                    n_state = S_FILL;
                end else begin
                    op      = OP_CLAMP_RD;
                    n_state = S_CLAMP;
                end
            end
            S_FILL: begin
                op = OP_FILL;
                if (i_sts.fill_last) begin
                    n_state = S_RES;
                end
            end
            S_CLAMP: begin
                op      = OP_CLAMP;
                n_state = S_SRD;
            end
            S_SRD: begin
                if (i_sts.srch_more) begin
                    op      = OP_SRCH_RD;
                    n_state = S_SCMP;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_SCMP: begin
                if (i_sts.srch_less) begin
                    op      = OP_SRCH_INC;
                    n_state = S_SRD;
                end else begin
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                op      = OP_LOAD_RD;
                n_state = S_LPUSH;
            end
            S_LPUSH: begin
                op      = OP_LOAD_PSH;
                n_state = i_sts.lane_last ? S_STEP : S_LRD;
            end
            S_STEP: begin
                if (i_sts.lane_active) begin
                    op      = OP_STEP_RD;
                    n_state = S_KNOT;
                end else begin
                    op      = OP_ROTATE;
                    n_state = all_done ? S_FIN : S_STEP;
                end
            end
            S_KNOT: begin
                op      = OP_DIV;
                n_state = i_sts.den_zero ? S_MUL : S_DIVW;
            end
            S_DIVW: begin
                if (i_sts.div_done) begin
                    op      = OP_ALPHA;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                op      = OP_MUL;
                n_state = S_ADD;
            end
            S_ADD: begin
                op      = OP_ADD;
                n_state = i_sts.coord_last ? S_PUSH : S_MUL;
            end
            S_PUSH: begin
                op      = OP_BLD_PSH;
                n_state = all_done ? S_FIN : S_STEP;
            end
            S_FIN: begin
                op      = OP_FINISH;
                n_state = S_RES;
            end
            S_RES: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl.op = op;
    assign o_busy   = r_state != S_IDLE;
    assign o_done   = r_state == S_RES;

endmodule

/* sv/bspline_de_boor_evaluator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bspline_de_boor_evaluator
// 3-D B-spline store and evaluator (de Boor), signed Q16.16, saturating.
// ----------------------------------------------------------------------------
// One command is taken when start is high and busy is low; its result beat is
// shown for exactly one cycle with o_done and cannot be held off, so the user
// must sample it then. An evaluate runs clamp, linear span search and point
// load, then degree*(degree+1)/2 blends, each one pass of the 32-step shared
// divider (skipped on a zero knot difference) and three multiply/round steps.
// The user must write configuration only while busy is low; the block itself
// does not enforce it. o_cfg_ready is always high.
// ----------------------------------------------------------------------------
module bspline_de_boor_evaluator #(
    parameter int MAX_POINTS = bdb_pkg::MaxPointsDef,
    parameter int MAX_DEGREE = bdb_pkg::MaxDegreeDef
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bdb_pkg::t_in  i_item,
    output logic          o_done,
    output bdb_pkg::t_out o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import bdb_pkg::*;

    t_ctl ctl;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bdb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bdb_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .MAX_DEGREE (MAX_DEGREE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

/* tb/bdb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdb_checker
// Predicts and checks every result beat of the B-spline evaluator.
// ----------------------------------------------------------------------------
// Tracks configuration writes and accepted commands, keeps its own copy of the
// point and knot stores, computes each expected result by de Boor blending and
// compares the result beats in order, field by field.
// ----------------------------------------------------------------------------
module bdb_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  bdb_pkg::t_in  i_item,
    input  logic          i_done,
    input  bdb_pkg::t_out i_result,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_cmds_seen,
    output int            o_evals_ok,
    output int            o_zero_den
);
    import bdb_pkg::*;

    localparam int NumPts   = 64;
    localparam int NumKnots = 68;
    localparam int MaxDeg   = 3;
    localparam longint CoordHi = 64'sd2147483647;
    localparam longint CoordLo = -64'sd2147483648;
    localparam longint AlphaOne = 64'sd1 << 30;

    longint pt_x [NumPts];
    longint pt_y [NumPts];
    longint pt_z [NumPts];
    longint knots [NumKnots];
    int     deg;
    int     pcount;
    longint interval;
    t_out   spline_results_q [$];

    function automatic longint sat32(input longint v);
        if (v > CoordHi) return CoordHi;
        if (v < CoordLo) return CoordLo;
        return v;
    endfunction

    function automatic longint blend_pt(input longint lo, input longint hi,
                                        input longint alpha);
        longint prod;
        prod = alpha * (hi - lo) + (64'sd1 <<< 29);
        return sat32(lo + (prod >>> 30));
    endfunction

    function automatic logic [1:0] cfg_status();
        if (deg == 0 || deg > MaxDeg || pcount > NumPts) return ST_RANGE;
        if (pcount < deg + 1) return ST_FEW_PTS;
        return ST_OK;
    endfunction

    task automatic eval_spline_cmd(input t_in it, output t_out r);
        int     idx;
        int     k;
        longint ub;
        longint lo;
        longint hi;
        longint ka;
        longint kb;
        longint den;
        longint alpha;
        longint d [MaxDeg+1][3];
        r = '0;
        idx = int'(it.entry_index);
        case (it.cmd)
            CMD_WR_POINT: begin
                if (idx < NumPts) begin
                    pt_x[idx] = longint'($signed(it.coord_x));
                    pt_y[idx] = longint'($signed(it.coord_y));
                    pt_z[idx] = longint'($signed(it.coord_z));
                end else begin
                    r.status = ST_RANGE;
                end
            end
            CMD_WR_KNOT: begin
                if (idx < NumKnots) knots[idx] = longint'($signed(it.knot_value));
                else r.status = ST_RANGE;
            end
            CMD_FILL: begin
                r.status = cfg_status();
                if (r.status == ST_OK) begin
                    for (int i = 0; i <= pcount + deg; i++) begin
                        knots[i] = sat32(longint'(i - deg) * interval);
                    end
                end
            end
            default: begin
                r.status = cfg_status();
                if (r.status == ST_OK) begin
                    lo = knots[deg];
                    hi = knots[pcount];
                    ub = longint'($signed(it.param_u));
                    if (ub < lo) ub = lo;
                    if (ub > hi) ub = hi;
                    k = deg;
                    while (k + 1 < pcount && knots[k+1] < ub) k++;
                    for (int i = 0; i <= deg; i++) begin
                        d[i][0] = pt_x[k-deg+i];
                        d[i][1] = pt_y[k-deg+i];
                        d[i][2] = pt_z[k-deg+i];
                    end
                    for (int rd = 1; rd <= deg; rd++) begin
                        for (int i = deg; i >= rd; i--) begin
                            ka = knots[i+k-deg];
                            kb = knots[i+1+k-rd];
                            den = kb - ka;
                            alpha = 0;
                            if (den == 0) begin
                                r.status = ST_ZERO_DEN;
                            end else begin
                                alpha = ((ub - ka) * AlphaOne) / den;
                                if (alpha > 2 * AlphaOne) alpha = 2 * AlphaOne;
                                if (alpha < -2 * AlphaOne) alpha = -2 * AlphaOne;
                            end
                            for (int c = 0; c < 3; c++) begin
                                d[i][c] = blend_pt(d[i-1][c], d[i][c], alpha);
                            end
                        end
                    end
                    r.pos_x = d[deg][0][31:0];
                    r.pos_y = d[deg][1][31:0];
                    r.pos_z = d[deg][2][31:0];
                    r.span_found = 7'(k);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            deg = 3;
            pcount = 4;
            interval = 65536;
            foreach (pt_x[i]) begin
                pt_x[i] = 0;
                pt_y[i] = 0;
                pt_z[i] = 0;
            end
            foreach (knots[i]) knots[i] = 0;
            spline_results_q.delete();
            o_errors = 0;
            o_cmds_seen = 0;
            o_evals_ok = 0;
            o_zero_den = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEGREE:   deg = int'(i_cfg_data[1:0]);
                    CFG_PCOUNT:   pcount = int'(i_cfg_data[6:0]);
                    CFG_INTERVAL: interval = longint'(i_cfg_data[30:0]);
                    default: ;
                endcase
            end
            if (i_done) begin
                if (spline_results_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("[%0t] ERROR: result beat with nothing pending", $time);
                end else begin
                    want = spline_results_q.pop_front();
                    if (i_result.pos_x !== want.pos_x || i_result.pos_y !== want.pos_y ||
                        i_result.pos_z !== want.pos_z ||
                        i_result.span_found !== want.span_found ||
                        i_result.status !== want.status) begin
                        o_errors++;
                        if (o_errors <= 10) begin
                            $display("[%0t] ERROR: exp x=%h y=%h z=%h span=%0d st=%0d",
                                     $time, want.pos_x, want.pos_y, want.pos_z,
                                     want.span_found, want.status);
                            $display("[%0t]        got x=%h y=%h z=%h span=%0d st=%0d",
                                     $time, i_result.pos_x, i_result.pos_y,
                                     i_result.pos_z, i_result.span_found,
                                     i_result.status);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                eval_spline_cmd(i_item, want);
                spline_results_q = {spline_results_q, want};
                o_cmds_seen++;
                if (i_item.cmd == CMD_EVAL && want.status == ST_OK) o_evals_ok++;
                if (i_item.cmd == CMD_EVAL && want.status == ST_ZERO_DEN) o_zero_den++;
            end
        end
        o_pending = spline_results_q.size();
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the B-spline evaluator.
// ----------------------------------------------------------------------------
// Loads every point and knot, runs directed corner commands, then phases of
// random commands under several degree / point count / interval settings with
// random gaps between beats. bdb_checker predicts and compares the results.
// ----------------------------------------------------------------------------
module tb_top;
    import bdb_pkg::*;

    localparam int WatchdogLimit = 5000;
    localparam int InW           = $bits(t_in);

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_in         i_item;
    logic        o_done;
    t_out        o_result;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int     errors;
    int     pending;
    int     cmds_seen;
    int     evals_ok;
    int     zero_den;
    int     idle_cycles;
    int     cur_deg;
    int     cur_pc;
    longint cur_iv;

    bspline_de_boor_evaluator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    bdb_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_busy     (busy),
        .i_item     (i_item),
        .i_done     (o_done),
        .i_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_cmds_seen(cmds_seen),
        .o_evals_ok (evals_ok),
        .o_zero_den (zero_den)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WatchdogLimit) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_cmd(input t_in it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_item <= it;
        start <= 1'b1;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending != 0 || busy) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        while (!o_cfg_ready) @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_DEGREE:   cur_deg = int'(val[1:0]);
            CFG_PCOUNT:   cur_pc = int'(val[6:0]);
            CFG_INTERVAL: cur_iv = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic set_config(input int d, input int pc, input logic [31:0] iv);
        drain();
        write_reg(CFG_DEGREE, 32'(d));
        write_reg(CFG_PCOUNT, 32'(pc));
        write_reg(CFG_INTERVAL, iv);
    endtask

    function automatic t_in make_cmd(input logic [1:0] cmd, input int idx, input longint v);
        t_in it;
        it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        it.cmd = cmd;
        it.entry_index = 7'(idx);
        it.knot_value = v[31:0];
        it.param_u = v[31:0];
        return it;
    endfunction

    function automatic longint knot_near(input int idx);
        return longint'(idx - cur_deg) * cur_iv;
    endfunction

    function automatic t_in rand_cmd();
        t_in     it;
        int      sel;
        longint  lo;
        longint  span;
        it = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            it.cmd = CMD_EVAL;
            lo = -cur_iv;
            span = longint'(cur_pc - cur_deg + 2) * cur_iv + 1;
            if (span < 1) span = 1;
            if ($urandom_range(0, 9) != 0)
                it.param_u = 32'(lo + longint'({$urandom, $urandom} % 64'(span)));
        end else if (sel < 72) begin
            it.cmd = CMD_WR_POINT;
            if ($urandom_range(0, 9) != 0) it.entry_index = 7'($urandom_range(0, 63));
            if ($urandom_range(0, 1) == 0) begin
                it.coord_x = 32'($signed(it.coord_x) >>> 8);
                it.coord_y = 32'($signed(it.coord_y) >>> 8);
                it.coord_z = 32'($signed(it.coord_z) >>> 8);
            end
        end else if (sel < 90) begin
            it.cmd = CMD_WR_KNOT;
            if ($urandom_range(0, 9) != 0) it.entry_index = 7'($urandom_range(0, 67));
            case ($urandom_range(0, 3))
                0: ;
                1: it.knot_value = 32'(knot_near(int'(it.entry_index) - 1));
                default: it.knot_value = 32'(knot_near(int'(it.entry_index)) +
                                             longint'($urandom_range(0, 2000)) - 1000);
            endcase
        end else begin
            it.cmd = CMD_FILL;
        end
        return it;
    endfunction

    initial begin
        int pc;
        int d;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_DEGREE;
        i_cfg_data = '0;
        cur_deg = 3;
        cur_pc = 4;
        cur_iv = 65536;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // load every entry so no evaluate ever touches an unwritten location
        for (int i = 0; i < 64; i++) send_cmd(make_cmd(CMD_WR_POINT, i, 0));
        for (int i = 0; i < 68; i++) send_cmd(make_cmd(CMD_WR_KNOT, i, knot_near(i)));

        // directed corners
        begin
            t_in it;
            it = make_cmd(CMD_WR_POINT, 0, 0);
            it.coord_x = 32'h7FFFFFFF; it.coord_y = 32'h80000000; it.coord_z = 32'h7FFFFFFF;
            send_cmd(it);
            it = make_cmd(CMD_WR_POINT, 1, 0);
            it.coord_x = 32'h80000000; it.coord_y = 32'h7FFFFFFF; it.coord_z = 32'h80000000;
            send_cmd(it);
            send_cmd(make_cmd(CMD_WR_POINT, 64, 0));
            send_cmd(make_cmd(CMD_WR_POINT, 127, 0));
            send_cmd(make_cmd(CMD_WR_KNOT, 68, 0));
            send_cmd(make_cmd(CMD_WR_KNOT, 127, 0));
            send_cmd(make_cmd(CMD_EVAL, 0, -64'sd2147483648));
            send_cmd(make_cmd(CMD_EVAL, 0, 64'sd2147483647));
            send_cmd(make_cmd(CMD_EVAL, 0, 32768));
            send_cmd(make_cmd(CMD_WR_KNOT, 4, 0));
            send_cmd(make_cmd(CMD_EVAL, 0, 0));
            send_cmd(make_cmd(CMD_FILL, 0, 0));
            send_cmd(make_cmd(CMD_EVAL, 0, 40000));
        end
        set_config(0, 4, 65536);
        send_cmd(make_cmd(CMD_EVAL, 0, 0));
        send_cmd(make_cmd(CMD_FILL, 0, 0));
        set_config(3, 127, 65536);
        send_cmd(make_cmd(CMD_EVAL, 0, 0));
        send_cmd(make_cmd(CMD_FILL, 0, 0));
        set_config(3, 2, 65536);
        send_cmd(make_cmd(CMD_EVAL, 0, 0));
        send_cmd(make_cmd(CMD_FILL, 0, 0));
        set_config(1, 2, 1);
        send_cmd(make_cmd(CMD_FILL, 0, 0));
        send_cmd(make_cmd(CMD_EVAL, 0, 1));
        set_config(3, 64, 32'h7FFFFFFF);
        send_cmd(make_cmd(CMD_FILL, 0, 0));
        send_cmd(make_cmd(CMD_EVAL, 0, 64'sd2147483647));

        // random phases, one setting each
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: set_config(1, 2, 65536);
                1: set_config(3, 64, 32'h7FFFFFFF);
                2: set_config(1, 64, 1);
                3: set_config(2, 3, 32'h55555555);
                default: begin
                    d = $urandom_range(1, 3);
                    pc = $urandom_range(0, 3) == 0 ? $urandom_range(d + 1, 64)
                                                   : $urandom_range(d + 1, 12);
                    set_config(d, pc, $urandom);
                end
            endcase
            send_cmd(make_cmd(CMD_FILL, 0, 0));
            for (int n = 0; n < 80; n++) send_cmd(rand_cmd());
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Run covered %0d commands under 14 register settings; %0d evaluates ok,",
                 cmds_seen, evals_ok);
        $display("%0d evaluates hit a zero knot difference.", zero_den);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* files.f */
sv/bdb_pkg.sv
sv/bdb_div.sv
sv/bdb_datapath.sv
sv/bdb_ctrl.sv
sv/bspline_de_boor_evaluator.sv
tb/bdb_checker.sv
tb/tb_top.sv
